// ----- rtl/fixed_point_alu_core_defines.svh -----
// ----------------------------------------------------------------------------
// fixed_point_alu_core_defines.svh
// Assertion macros shared by the fixed-point ALU RTL.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_CORE_DEFINES_SVH
`define FIXED_POINT_ALU_CORE_DEFINES_SVH

// checked only out of reset
`define FPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Types, codes and sizing for the signed fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package fpa_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int WORD_W     = 32;
	localparam int DIV_BITS   = 2;	// quotient bits resolved per divider stage
	localparam int DVD_W      = WORD_W + FRAC_BITS;
	localparam int DIV_STAGES = (DVD_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DQ_W       = DIV_STAGES * DIV_BITS;

	localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);

	typedef enum logic [3:0] {
		OP_ADD = 4'd0,
		OP_SUB = 4'd1,
		OP_MUL = 4'd2,
		OP_DIV = 4'd3,
		OP_INC = 4'd4,
		OP_DEC = 4'd5,
		OP_GT  = 4'd6,
		OP_LT  = 4'd7,
		OP_GE  = 4'd8,
		OP_LE  = 4'd9,
		OP_EQ  = 4'd10,
		OP_NE  = 4'd11
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

	typedef struct packed {
		logic [3:0]               operation;
		logic signed [WORD_W-1:0] operand_a;
		logic signed [WORD_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic                     compare_true;
		status_t                  status;
	} rsp_t;

	// In-flight item: dq holds dividend bits shifting out and quotient bits
	// shifting in; for multiply it holds the rounded product magnitude.
	typedef struct packed {
		logic              is_div;
		logic              use_mag;
		logic              neg;
		logic [WORD_W-1:0] dvs;
		logic [WORD_W-1:0] rem;
		logic [DQ_W-1:0]   dq;
		rsp_t              res;
	} work_t;

	// one restoring division step
	function automatic work_t div_step(work_t w);
		logic [WORD_W:0] trial;
		logic [WORD_W:0] diff;
		logic            q_bit;
		work_t           o;
		o     = w;
		trial = {w.rem, w.dq[DQ_W-1]};
		diff  = trial - {1'b0, w.dvs};
		q_bit = (trial >= {1'b0, w.dvs});
		o.rem = q_bit ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
		o.dq  = {w.dq[DQ_W-2:0], q_bit};
		return o;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/fpa_div.sv -----
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, DIV_BITS quotient bits per stage. Items that
// are not divides pass through untouched.
// ----------------------------------------------------------------------------
`default_nettype none

module fpa_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire fpa_pkg::work_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output fpa_pkg::work_t     out_data
);

	localparam int DS = fpa_pkg::DIV_STAGES;

	fpa_pkg::work_t stage_s [DS];
	fpa_pkg::work_t nxt     [DS];
	logic [DS-1:0]  vld_s;
	logic [DS-1:0]  en;

	genvar g;
	generate
		for (g = 0; g < DS; g++) begin : g_stage
			fpa_pkg::work_t src;
			logic           src_vld;

			if (g == 0) begin : g_first
				assign src     = in_data;
				assign src_vld = in_valid;
			end else begin : g_rest
				assign src     = stage_s[g-1];
				assign src_vld = vld_s[g-1];
			end

			if (g == DS - 1) begin : g_en_last
				assign en[g] = !vld_s[g] || !out_stall;
			end else begin : g_en
				assign en[g] = !vld_s[g] || en[g+1];
			end

			always_comb begin
				fpa_pkg::work_t w;
				w = src;
				if (src.is_div) begin
					for (int i = 0; i < fpa_pkg::DIV_BITS; i++) begin
						w = fpa_pkg::div_step(w);
					end
				end
				nxt[g] = w;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[g] <= 1'b0;
				end else if (en[g]) begin
					vld_s[g] <= src_vld;
				end
			end

			always_ff @(posedge clk) begin
				if (en[g]) begin
					stage_s[g] <= nxt[g];
				end
			end
		end
	endgenerate

	assign in_stall  = !en[0];
	assign out_valid = vld_s[DS-1];
	assign out_data  = stage_s[DS-1];

endmodule

`default_nettype wire

// ----- rtl/fixed_point_alu_core.sv -----
// Path: each item is registered in stage 1, stage 2, every divider stage and stage 3
// from accept to result valid; the divider resolves two quotient bits a stage.
// Throughput: one transaction per cycle while the result side does not stall; every operation takes the same path.
// Empty stages close up while the result side stalls.
// Reset: arst_n clears all stage valid bits; no other register is reset.
// ----------------------------------------------------------------------------
// fixed_point_alu_core
// Signed fixed-point ALU: add, sub, multiply, divide, inc, dec and compares.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fixed_point_alu_core_defines.svh"

module fixed_point_alu_core (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      op_valid,
	output logic           op_stall,
	input  wire fpa_pkg::req_t op_data,
	output logic           res_valid,
	input  wire logic      res_stall,
	output fpa_pkg::rsp_t  res_data
);

	localparam int W  = fpa_pkg::WORD_W;
	localparam int DQ = fpa_pkg::DQ_W;

	// ---------------- stage 1: decode, add/sub/inc/dec, compare, multiply, divide setup
	fpa_pkg::work_t w1_d;
	logic           mul_d;
	logic           vld_s1, vld_s2, vld_s3;
	logic           en_s1, en_s2, en_s3;
	fpa_pkg::work_t w_s1, w_s2;
	logic           mul_s1;
	logic signed [63:0] prod_s1;
	fpa_pkg::rsp_t  res_s3;

	always_comb begin
		logic signed [W:0] a_x;
		logic signed [W:0] b_x;
		logic signed [W:0] sum;
		logic [W-1:0]      a_mag;
		a_x   = {op_data.operand_a[W-1], op_data.operand_a};
		b_x   = {op_data.operand_b[W-1], op_data.operand_b};
		a_mag = op_data.operand_a[W-1] ? (W)'(-op_data.operand_a) : op_data.operand_a;
		sum   = '0;
		mul_d = 1'b0;

		w1_d.is_div  = 1'b0;
		w1_d.use_mag = 1'b0;
		w1_d.neg     = op_data.operand_a[W-1] ^ op_data.operand_b[W-1];
		w1_d.dvs     = op_data.operand_b[W-1] ? (W)'(-op_data.operand_b)
		                                     : op_data.operand_b;
		w1_d.rem     = '0;
		w1_d.dq      = (DQ)'({a_mag, {fpa_pkg::FRAC_BITS{1'b0}}});
		w1_d.res     = '0;
		w1_d.res.status = fpa_pkg::ST_OK;

		case (fpa_pkg::op_t'(op_data.operation))
			fpa_pkg::OP_ADD: sum = a_x + b_x;
			fpa_pkg::OP_SUB: sum = a_x - b_x;
			fpa_pkg::OP_INC: sum = a_x + (W+1)'(1);
			fpa_pkg::OP_DEC: sum = a_x - (W+1)'(1);
			default:         sum = '0;
		endcase

		case (fpa_pkg::op_t'(op_data.operation))
			fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
				if (sum[W] != sum[W-1]) begin
					w1_d.res.status = fpa_pkg::ST_OVF;
				end else begin
					w1_d.res.result_value = sum[W-1:0];
				end
			end
			fpa_pkg::OP_MUL: mul_d = 1'b1;
			fpa_pkg::OP_DIV: begin
				if (op_data.operand_b == '0) begin
					w1_d.res.status = fpa_pkg::ST_DIVZ;
				end else begin
					w1_d.is_div  = 1'b1;
					w1_d.use_mag = 1'b1;
				end
			end
			fpa_pkg::OP_GT: w1_d.res.compare_true = (op_data.operand_a >  op_data.operand_b);
			fpa_pkg::OP_LT: w1_d.res.compare_true = (op_data.operand_a <  op_data.operand_b);
			fpa_pkg::OP_GE: w1_d.res.compare_true = (op_data.operand_a >= op_data.operand_b);
			fpa_pkg::OP_LE: w1_d.res.compare_true = (op_data.operand_a <= op_data.operand_b);
			fpa_pkg::OP_EQ: w1_d.res.compare_true = (op_data.operand_a == op_data.operand_b);
			fpa_pkg::OP_NE: w1_d.res.compare_true = (op_data.operand_a != op_data.operand_b);
			default: ;
		endcase
	end

	// ---------------- stage 2: multiply rounding, half away from zero
	fpa_pkg::work_t w2_d;

	always_comb begin
		logic [63:0] mag;
		logic [63:0] rnd;
		w2_d = w_s1;
		mag  = prod_s1[63] ? 64'(-prod_s1) : 64'(prod_s1);
		rnd  = (mag + fpa_pkg::ROUND_HALF) >> fpa_pkg::FRAC_BITS;
		if (mul_s1) begin
			w2_d.is_div  = 1'b0;
			w2_d.use_mag = 1'b1;
			w2_d.neg     = prod_s1[63];
			w2_d.dq      = (|rnd[63:DQ]) ? '1 : rnd[DQ-1:0];
		end
	end

	// ---------------- divider stages
	logic           dv_stall;
	logic           dv_valid;
	fpa_pkg::work_t dv_data;

	fpa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_stall  (dv_stall),
		.in_data   (w_s2),
		.out_valid (dv_valid),
		.out_stall (!en_s3),
		.out_data  (dv_data)
	);

	// ---------------- stage 3: sign and range of magnitude results
	fpa_pkg::rsp_t res_d;

	always_comb begin
		logic [DQ-1:0] q;
		logic          ovf;
		q     = dv_data.dq;
		ovf   = dv_data.neg ? (q > (DQ)'(33'h1_0000_0000 >> 1))
		                    : (q > (DQ)'(32'h7fff_ffff));
		res_d = dv_data.res;
		if (dv_data.use_mag) begin
			res_d.compare_true = 1'b0;
			if (ovf) begin
				res_d.result_value = '0;
				res_d.status       = fpa_pkg::ST_OVF;
			end else begin
				res_d.result_value = dv_data.neg ? -q[W-1:0] : q[W-1:0];
				res_d.status       = fpa_pkg::ST_OK;
			end
		end
	end

	// ---------------- handshake chain
	assign en_s3    = !vld_s3 || !res_stall;
	assign en_s2    = !vld_s2 || !dv_stall;
	assign en_s1    = !vld_s1 || en_s2;
	assign op_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= op_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			w_s1    <= w1_d;
			mul_s1  <= mul_d;
			prod_s1 <= op_data.operand_a * op_data.operand_b;
		end
		if (en_s2) begin
			w_s2 <= w2_d;
		end
		if (en_s3) begin
			res_s3 <= res_d;
		end
	end

	assign res_valid = vld_s3;
	assign res_data  = res_s3;

	`FPA_ASSERT(a_err_zeroes, res_valid && res_data.status != fpa_pkg::ST_OK |-> res_data.result_value == '0 && !res_data.compare_true, "error status with nonzero payload")
	`FPA_ASSERT(a_cmp_clean, res_valid && res_data.compare_true |-> res_data.status == fpa_pkg::ST_OK && res_data.result_value == '0, "compare result with value or status")
	`FPA_ASSERT(a_full_stall, op_stall |-> res_valid && res_stall, "input stalled while output drains")
	`FPA_ASSERT_ALWAYS(a_rst_idle, !arst_n |-> !res_valid, "result valid during reset")

endmodule

`default_nettype wire
